// File: hdl/rrl_pkg.sv
`default_nettype none

package rrl_pkg;

   // width of every address field on the ports
   localparam int WORD_BITS = 32;

   // depth of the word queue between intake and lookup engine
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_QUERY    = 1'b0,
      OP_REGISTER = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } scan_state_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      op_type                 op;
      logic [WORD_BITS-1:0]   code_address;
      logic [WORD_BITS-1:0]   region_end;
      logic [WORD_BITS-1:0]   restart_address;
   } item_type;

endpackage

`default_nettype wire

// File: hdl/restart_region_lookup.sv
`default_nettype none

// Restart region lookup.
// Keeps up to MAX_REGIONS code regions (start, exclusive end, restart address).
// Input channel: drive start high with req_* valid; the word is taken at a
// rising edge where start is high and busy is low. req_action = 1 registers a
// region (same start overwrites it, a full table drops it with rsp_status = 1);
// req_action = 0 queries a program counter in req_code_address.
// Result channel: one word per input word, shown for one cycle with rsp_strobe.
// A query answers rsp_in_region = 1 and the restart address when the counter
// lies strictly inside the region with the greatest start not above it.
// With the engine idle, an accepted word passes the queue and the engine states
// IDLE, SCAN, LAST and DONE before the registered rsp_strobe rises. The engine
// takes no new word until it is back in IDLE, as it reads one table slot per
// cycle from the single table read port. A two-word queue in front lets new
// words be taken while a lookup runs; busy rises when it is full.
// Reset clears the queue, the engine and all slot valid bits (empty table).
// The receiver cannot stall; every result is taken in its strobe cycle.
module restart_region_lookup #(
   parameter int MAX_REGIONS = 16,
   parameter int ADDR_BITS   = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [rrl_pkg::WORD_BITS-1:0] req_code_address,
   input  wire logic [rrl_pkg::WORD_BITS-1:0] req_region_end,
   input  wire logic [rrl_pkg::WORD_BITS-1:0] req_restart_address,
   output logic                               rsp_strobe,
   output logic                               rsp_in_region,
   output logic [rrl_pkg::WORD_BITS-1:0]      rsp_resume_address,
   output logic                               rsp_status
);
   import rrl_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_pop;

   rrl_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_code_address    (req_code_address),
      .req_region_end      (req_region_end),
      .req_restart_address (req_restart_address),
      .item_valid          (item_valid),
      .item                (item),
      .item_pop            (item_pop)
   );

   rrl_back #(
      .MAX_REGIONS (MAX_REGIONS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_in_region      (rsp_in_region),
      .rsp_resume_address (rsp_resume_address),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

// File: hdl/rrl_front.sv
`default_nettype none

module rrl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [rrl_pkg::WORD_BITS-1:0] req_code_address,
   input  wire logic [rrl_pkg::WORD_BITS-1:0] req_region_end,
   input  wire logic [rrl_pkg::WORD_BITS-1:0] req_restart_address,
   output logic                               item_valid,
   output rrl_pkg::item_type                  item,
   input  wire logic                          item_pop
);
   import rrl_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type              queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push;
   item_type              new_item;

   // classify the incoming word
   always_comb begin
      new_item.op              = req_action ? OP_REGISTER : OP_QUERY;
      new_item.code_address    = req_code_address;
      new_item.region_end      = req_region_end;
      new_item.restart_address = req_restart_address;
   end

   assign busy       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold the word in the queue
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rrl_back.sv
`default_nettype none

module rrl_back #(
   parameter int MAX_REGIONS = 16,
   parameter int ADDR_BITS   = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire rrl_pkg::item_type             item,
   output logic                               item_pop,
   output logic                               rsp_strobe,
   output logic                               rsp_in_region,
   output logic [rrl_pkg::WORD_BITS-1:0]      rsp_resume_address,
   output logic                               rsp_status
);
   import rrl_pkg::*;

   localparam int IDX_BITS   = $clog2(MAX_REGIONS);
   localparam int STORE_BITS = (ADDR_BITS < WORD_BITS) ? ADDR_BITS : WORD_BITS;

   // region table
   logic [STORE_BITS-1:0]  start_mem  [MAX_REGIONS];
   logic [STORE_BITS-1:0]  end_mem    [MAX_REGIONS];
   logic [STORE_BITS-1:0]  resume_mem [MAX_REGIONS];
   logic [MAX_REGIONS-1:0] slot_valid_ff;

   scan_state_type         state_ff, state_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;

   // current word
   op_type                 op_ff;
   logic [STORE_BITS-1:0]  addr_ff;
   logic [STORE_BITS-1:0]  end_ff;
   logic [STORE_BITS-1:0]  resume_ff;

   // read stage
   logic [STORE_BITS-1:0]  rd_start_ff;
   logic [STORE_BITS-1:0]  rd_end_ff;
   logic [STORE_BITS-1:0]  rd_resume_ff;
   logic                   rd_valid_ff;
   logic                   eval_ff;
   logic [IDX_BITS-1:0]    eval_idx_ff;

   // scan results
   logic                   best_found_ff;
   logic [STORE_BITS-1:0]  best_start_ff;
   logic [STORE_BITS-1:0]  best_end_ff;
   logic [STORE_BITS-1:0]  best_resume_ff;
   logic                   match_found_ff;
   logic [IDX_BITS-1:0]    match_idx_ff;
   logic                   free_found_ff;
   logic [IDX_BITS-1:0]    free_idx_ff;

   logic                   load;
   logic                   scan_active;
   logic                   finish;
   logic                   hit_match;
   logic                   hit_free;
   logic                   hit_best;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_idx;
   logic                   query_hit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == IDX_BITS'(MAX_REGIONS - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load        = 1'b0;
      scan_active = 1'b0;
      finish      = 1'b0;
      case (state_ff)
         ST_IDLE: load        = item_valid;
         ST_SCAN: scan_active = 1'b1;
         ST_LAST: ;
         ST_DONE: finish      = 1'b1;
         default: ;
      endcase
   end

   assign item_pop = load;
   assign idx_in   = load ? '0 : (scan_active ? idx_ff + 1'b1 : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         eval_ff       <= 1'b0;
         slot_valid_ff <= '0;
         rsp_strobe    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         eval_ff    <= scan_active;
         rsp_strobe <= finish;
         if (wr_en) begin
            slot_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // latch the word, masked to the stored address width
   always_ff @(posedge clock) begin
      if (load) begin
         op_ff     <= item.op;
         addr_ff   <= item.code_address[STORE_BITS-1:0];
         end_ff    <= item.region_end[STORE_BITS-1:0];
         resume_ff <= item.restart_address[STORE_BITS-1:0];
      end
   end

   // table write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_idx]  <= addr_ff;
         end_mem[wr_idx]    <= end_ff;
         resume_mem[wr_idx] <= resume_ff;
      end
      rd_start_ff  <= start_mem[idx_ff];
      rd_end_ff    <= end_mem[idx_ff];
      rd_resume_ff <= resume_mem[idx_ff];
      rd_valid_ff  <= slot_valid_ff[idx_ff];
      eval_idx_ff  <= idx_ff;
   end

   // evaluate one slot per cycle
   assign hit_match = eval_ff && rd_valid_ff && (rd_start_ff == addr_ff);
   assign hit_free  = eval_ff && !rd_valid_ff;
   assign hit_best  = eval_ff && rd_valid_ff && (rd_start_ff <= addr_ff)
                      && (!best_found_ff || (rd_start_ff > best_start_ff));

   always_ff @(posedge clock) begin
      if (load) begin
         best_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         if (hit_match && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= eval_idx_ff;
         end
         if (hit_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx_ff;
         end
         if (hit_best) begin
            best_found_ff  <= 1'b1;
            best_start_ff  <= rd_start_ff;
            best_end_ff    <= rd_end_ff;
            best_resume_ff <= rd_resume_ff;
         end
      end
   end

   // commit a register word: overwrite a same-start slot, else take the lowest free one
   assign wr_en  = finish && (op_ff == OP_REGISTER) && (match_found_ff || free_found_ff);
   assign wr_idx = match_found_ff ? match_idx_ff : free_idx_ff;

   assign query_hit = (op_ff == OP_QUERY) && best_found_ff
                      && (addr_ff > best_start_ff) && (addr_ff < best_end_ff);

   // drive the result word
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_in_region      <= query_hit;
         rsp_resume_address <= query_hit ? WORD_BITS'(best_resume_ff) : '0;
         rsp_status         <= ((op_ff == OP_REGISTER) && !match_found_ff && !free_found_ff)
                               ? STATUS_FULL : STATUS_OK;
      end
   end

endmodule

`default_nettype wire
